FILE: design/tcw_pkg.sv
package tcw_pkg;

   // Default screen geometry
   localparam int unsigned COLUMNS_DEF = 80;
   localparam int unsigned ROWS_DEF    = 25;

   // Item field widths
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned CADDR_W  = 11;
   localparam int unsigned CURSOR_W = 11;
   localparam int unsigned CELL_W   = 16;
   localparam int unsigned ATTR_W   = 8;

   // Cell constants
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

   // Register port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_TEXT_ATTR = 1'b0;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUT   = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_READ  = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_TAIL,
      ST_FILL,
      ST_REPLY
   } state_type;

endpackage

FILE: design/tcw_req_if.sv
interface tcw_req_if
   import tcw_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [CHAR_W-1:0]   char_code;
   logic [CADDR_W-1:0]  cell_address;

   modport source (output valid, action, char_code, cell_address, input ready);
   modport sink   (input valid, action, char_code, cell_address, output ready);
endinterface

FILE: design/tcw_rsp_if.sv
interface tcw_rsp_if
   import tcw_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [CURSOR_W-1:0] cursor_position;
   logic                scrolled;
   logic [CELL_W-1:0]   cell_word;

   modport source (output valid, cursor_position, scrolled, cell_word, input ready);
   modport sink   (input valid, cursor_position, scrolled, cell_word, output ready);
endinterface

FILE: design/tcw_ram.sv
module tcw_ram
   import tcw_pkg::*;
#(
   parameter  int unsigned WIDTH  = CELL_W,
   parameter  int unsigned DEPTH  = COLUMNS_DEF * ROWS_DEF,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/text_console_writer.sv
// Text-mode console engine: a ROWS x COLUMNS store of 16-bit cells
// (attribute high byte, character low byte) and a cursor.
// req_port takes one item: put a character (10 is newline), clear the
// screen, or read one cell. rsp_port returns one item per request with
// the cursor after the request, a scroll flag and the read cell word.
// The csr_ port holds text_attribute at byte address 0 (reset value 15);
// write it only while the block is idle.
// Operation: a put without scroll, an out-of-range read or an unused
// action goes straight to the reply; an in-range read first waits for the
// registered RAM read. A put that scrolls copies the screen up one row
// through the cell RAM (one read and one write port, one cell per cycle)
// and then blanks the last row. Clear blanks every cell, one per cycle.
// req_port is ready only between items. After reset the RAM is blanked
// in one pass before the first item is taken.
// The result sits in an output register; while rsp_port is stalled the
// next item is still taken, and only its final hand-off waits.
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int unsigned COLUMNS = COLUMNS_DEF,
   parameter int unsigned ROWS    = ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tcw_req_if.sink               req_port,
   tcw_rsp_if.source             rsp_port,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
   localparam int unsigned AW         = $clog2(CELL_COUNT);
   localparam int unsigned CW         = $clog2(CELL_COUNT + 1);
   localparam int unsigned COL_W      = $clog2(COLUMNS);

   state_type         state_ff, state_in;
   logic [CW-1:0]     cursor_ff, cursor_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic              cp_ff, cp_in;
   logic [AW-1:0]     cp_addr_ff, cp_addr_in;
   logic [CELL_W-1:0] fill_word_ff, fill_word_in;
   logic              reply_ff, reply_in;
   logic              scrolled_ff, scrolled_in;
   logic [CELL_W-1:0] word_ff, word_in;
   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CURSOR_W-1:0] rsp_cursor_ff, rsp_cursor_in;
   logic              rsp_scrolled_ff, rsp_scrolled_in;
   logic [CELL_W-1:0] rsp_word_ff, rsp_word_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [CELL_W-1:0] ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [CELL_W-1:0] ram_rdata;

   logic              accept;
   action_type        act;
   logic              is_nl;
   logic [CW-1:0]     cur_adv;
   logic              wrap;
   logic [COL_W-1:0]  col_next;
   logic              addr_ok;
   logic              out_free;
   logic              load_rsp;
   logic              csr_wr;
   logic [CELL_W-1:0] blank_word;

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[CSR_ADDR_W-1:2] == REG_TEXT_ATTR);
   assign attr_in    = csr_wr ? csr_pwdata[ATTR_W-1:0] : attr_ff;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_TEXT_ATTR)
                       ? CSR_DATA_W'(attr_ff) : '0;

   // Item decode and cursor arithmetic
   assign req_port.ready = (state_ff == ST_IDLE);
   assign accept   = req_port.valid && req_port.ready;
   assign act      = action_type'(req_port.action);
   assign is_nl    = (req_port.char_code == NEWLINE_CODE);
   assign cur_adv  = is_nl ? (cursor_ff - CW'(col_ff) + CW'(COLUMNS)) : (cursor_ff + 1'b1);
   assign wrap     = (cur_adv >= CW'(CELL_COUNT));
   assign col_next = (col_ff == COL_W'(COLUMNS - 1)) ? '0 : (col_ff + 1'b1);
   assign addr_ok  = (32'(req_port.cell_address) < 32'(CELL_COUNT));
   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign blank_word = {attr_ff, BLANK_CHAR};

   // Sequencer: next state, RAM port control
   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      col_in       = col_ff;
      idx_in       = idx_ff;
      cp_in        = 1'b0;
      cp_addr_in   = cp_addr_ff;
      fill_word_in = fill_word_ff;
      reply_in     = reply_ff;
      scrolled_in  = scrolled_ff;
      word_in      = word_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      ram_wdata    = fill_word_ff;
      ram_re       = 1'b0;
      ram_raddr    = idx_ff + AW'(COLUMNS);
      load_rsp     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               scrolled_in = 1'b0;
               word_in     = '0;
               case (act)
                  ACT_PUT: begin
                     if (is_nl) begin
                        col_in = '0;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(cursor_ff);
                        ram_wdata = {attr_ff, req_port.char_code};
                        col_in    = col_next;
                     end
                     if (wrap) begin
                        cursor_in   = cur_adv - CW'(COLUMNS);
                        scrolled_in = 1'b1;
                        idx_in      = '0;
                        state_in    = ST_SCROLL;
                     end else begin
                        cursor_in = cur_adv;
                        state_in  = ST_REPLY;
                     end
                  end
                  ACT_CLEAR: begin
                     cursor_in    = '0;
                     col_in       = '0;
                     idx_in       = '0;
                     fill_word_in = blank_word;
                     reply_in     = 1'b1;
                     state_in     = ST_FILL;
                  end
                  ACT_READ: begin
                     if (addr_ok) begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(req_port.cell_address);
                        state_in  = ST_READ;
                     end else begin
                        state_in = ST_REPLY;
                     end
                  end
                  default: begin
                     state_in = ST_REPLY;
                  end
               endcase
            end
         end
         ST_READ: begin
            word_in  = ram_rdata;
            state_in = ST_REPLY;
         end
         // copy one cell up a row per cycle: read ahead, write behind
         ST_SCROLL: begin
            if (cp_ff) begin
               ram_we    = 1'b1;
               ram_waddr = cp_addr_ff;
               ram_wdata = ram_rdata;
            end
            ram_re     = 1'b1;
            cp_in      = 1'b1;
            cp_addr_in = idx_ff;
            idx_in     = idx_ff + 1'b1;
            if (idx_ff == AW'(CELL_COUNT - COLUMNS - 1)) begin
               state_in = ST_TAIL;
            end
         end
         // last copied cell, then blank the bottom row
         ST_TAIL: begin
            ram_we       = 1'b1;
            ram_waddr    = cp_addr_ff;
            ram_wdata    = ram_rdata;
            fill_word_in = blank_word;
            reply_in     = 1'b1;
            state_in     = ST_FILL;
         end
         ST_FILL: begin
            ram_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == AW'(CELL_COUNT - 1)) begin
               idx_in   = '0;
               state_in = reply_ff ? ST_REPLY : ST_IDLE;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               load_rsp = 1'b1;
               reply_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register
   assign rsp_valid_in    = load_rsp || (rsp_valid_ff && !rsp_port.ready);
   assign rsp_cursor_in   = load_rsp ? CURSOR_W'(cursor_ff) : rsp_cursor_ff;
   assign rsp_scrolled_in = load_rsp ? scrolled_ff : rsp_scrolled_ff;
   assign rsp_word_in     = load_rsp ? word_ff : rsp_word_ff;

   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.cursor_position = rsp_cursor_ff;
   assign rsp_port.scrolled        = rsp_scrolled_ff;
   assign rsp_port.cell_word       = rsp_word_ff;

   // Control registers; reset starts the blanking pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         cursor_ff    <= '0;
         col_ff       <= '0;
         idx_ff       <= '0;
         cp_ff        <= 1'b0;
         fill_word_ff <= {RESET_ATTR, BLANK_CHAR};
         reply_ff     <= 1'b0;
         attr_ff      <= RESET_ATTR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         idx_ff       <= idx_in;
         cp_ff        <= cp_in;
         fill_word_ff <= fill_word_in;
         reply_ff     <= reply_in;
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cp_addr_ff      <= cp_addr_in;
      scrolled_ff     <= scrolled_in;
      word_ff         <= word_in;
      rsp_cursor_ff   <= rsp_cursor_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
      rsp_word_ff     <= rsp_word_in;
   end

   // Checks
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff < CW'(CELL_COUNT))
      else $error("cursor beyond screen");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < 32'(COLUMNS))
      else $error("column beyond row");

   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLY && scrolled_ff) |-> cursor_ff >= CW'(CELL_COUNT - COLUMNS))
      else $error("cursor not on last row after scroll");

   a_copy_phase: assert property (@(posedge clock) disable iff (reset)
      cp_ff |-> (state_ff == ST_SCROLL || state_ff == ST_TAIL))
      else $error("pending copy outside scroll");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !accept) |=> state_ff == ST_IDLE)
      else $error("left idle without an item");

endmodule
